// ===== hw/rtl/kdl_pkg.sv =====
// shared constants and types for the keypad door lock controller
// key classes, mode and status codes, register indexes, queue item type
// no dependencies
package kdl_pkg;

    localparam int CODE_DIGITS = 5;
    localparam int IDX_W       = $clog2(CODE_DIGITS + 1);
    localparam logic [IDX_W-1:0] CODE_LEN = IDX_W'(CODE_DIGITS);

    localparam int TICK_W   = 11;
    localparam int TRIES_W  = 3;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W   = 4;
    localparam int DIGIT_W  = 4;
    localparam int KEY_W    = 8;
    localparam int MOTOR_W  = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // key values
    localparam logic [KEY_W-1:0] KEY_ENTER   = 8'd13;
    localparam logic [KEY_W-1:0] KEY_MINUS   = 8'd45;
    localparam logic [KEY_W-1:0] KEY_PLUS    = 8'd43;
    localparam logic [KEY_W-1:0] KEY_MAX_DIG = 8'd9;

    // item classes
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] K_TICK  = 3'd0;
    localparam logic [KIND_W-1:0] K_DIGIT = 3'd1;
    localparam logic [KIND_W-1:0] K_ENTER = 3'd2;
    localparam logic [KIND_W-1:0] K_MINUS = 3'd3;
    localparam logic [KIND_W-1:0] K_PLUS  = 3'd4;
    localparam logic [KIND_W-1:0] K_OTHER = 3'd5;

    // modes and status codes
    localparam logic [MODE_W-1:0] M_MENU     = 4'd0;
    localparam logic [MODE_W-1:0] M_NEW1     = 4'd1;
    localparam logic [MODE_W-1:0] M_NEW2     = 4'd2;
    localparam logic [MODE_W-1:0] S_SAVED    = 4'd3;
    localparam logic [MODE_W-1:0] S_MISMATCH = 4'd4;
    localparam logic [MODE_W-1:0] M_OLD      = 4'd5;
    localparam logic [MODE_W-1:0] S_CORRECT  = 4'd6;
    localparam logic [MODE_W-1:0] S_WRONG    = 4'd7;
    localparam logic [MODE_W-1:0] M_LOCKED   = 4'd8;
    localparam logic [MODE_W-1:0] M_OPENING  = 4'd9;
    localparam logic [MODE_W-1:0] M_OPENED   = 4'd10;
    localparam logic [MODE_W-1:0] M_CLOSING  = 4'd11;

    // motor drive
    localparam logic [MOTOR_W-1:0] MOTOR_STOP = 2'd0;
    localparam logic [MOTOR_W-1:0] MOTOR_CW   = 2'd1;
    localparam logic [MOTOR_W-1:0] MOTOR_CCW  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIES     = 2'd3;

    localparam logic [TICK_W-1:0]  RST_OPEN_TICKS    = 11'd458;
    localparam logic [TICK_W-1:0]  RST_HOLD_TICKS    = 11'd92;
    localparam logic [TICK_W-1:0]  RST_LOCKOUT_TICKS = 11'd1832;
    localparam logic [TRIES_W-1:0] RST_MAX_TRIES     = 3'd3;
    localparam logic [TRIES_W-1:0] TRIES_SAT         = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DIGIT_W-1:0] digit;
    } t_item;

endpackage

// ===== hw/rtl/kdl_front.sv =====
// front end: accepts key and tick transactions and classifies them
// depends on kdl_pkg
module kdl_front (
    input  logic                      i_func,
    input  logic [kdl_pkg::KEY_W-1:0] i_key_code,
    output kdl_pkg::t_item            o_item
);

    always_comb begin
        o_item.digit = i_key_code[kdl_pkg::DIGIT_W-1:0];
        if (i_func) begin
            o_item.kind = kdl_pkg::K_TICK;
        end else if (i_key_code <= kdl_pkg::KEY_MAX_DIG) begin
            o_item.kind = kdl_pkg::K_DIGIT;
        end else if (i_key_code == kdl_pkg::KEY_ENTER) begin
            o_item.kind = kdl_pkg::K_ENTER;
        end else if (i_key_code == kdl_pkg::KEY_MINUS) begin
            o_item.kind = kdl_pkg::K_MINUS;
        end else if (i_key_code == kdl_pkg::KEY_PLUS) begin
            o_item.kind = kdl_pkg::K_PLUS;
        end else begin
            o_item.kind = kdl_pkg::K_OTHER;
        end
        if (o_item.kind != kdl_pkg::K_DIGIT) begin
            o_item.digit = '0;
        end
    end

endmodule

// ===== hw/rtl/kdl_queue.sv =====
// short queue of classified items between front and back
// depends on kdl_pkg
module kdl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  kdl_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output kdl_pkg::t_item o_item
);

    kdl_pkg::t_item                r_mem [kdl_pkg::QUEUE_DEPTH];
    logic [kdl_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [kdl_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [kdl_pkg::QCNT_W-1:0]    r_count;
    logic [kdl_pkg::QPTR_W-1:0]    n_wr_ptr;
    logic [kdl_pkg::QPTR_W-1:0]    n_rd_ptr;
    logic [kdl_pkg::QCNT_W-1:0]    n_count;

    assign o_full  = (r_count == kdl_pkg::QCNT_W'(kdl_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == kdl_pkg::QPTR_W'(kdl_pkg::QUEUE_DEPTH - 1)) ? '0
                     : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == kdl_pkg::QPTR_W'(kdl_pkg::QUEUE_DEPTH - 1)) ? '0
                     : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== hw/rtl/kdl_back.sv =====
// back end: lock state machine, code stores, tick counting, result register
// depends on kdl_pkg
module kdl_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kdl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kdl_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_item_valid,
    input  kdl_pkg::t_item                i_item,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [kdl_pkg::MODE_W-1:0]    o_status,
    output logic [kdl_pkg::MOTOR_W-1:0]   o_motor,
    output logic                          o_buzzer,
    output logic                          o_echo_valid,
    output logic [kdl_pkg::DIGIT_W-1:0]   o_echo_digit
);

    localparam int N  = kdl_pkg::CODE_DIGITS;
    localparam int DW = kdl_pkg::DIGIT_W;

    logic [kdl_pkg::TICK_W-1:0]  r_open_ticks;
    logic [kdl_pkg::TICK_W-1:0]  r_hold_ticks;
    logic [kdl_pkg::TICK_W-1:0]  r_lockout_ticks;
    logic [kdl_pkg::TRIES_W-1:0] r_max_tries;

    logic [kdl_pkg::MODE_W-1:0]  r_mode,  n_mode;
    logic                        r_pc,    n_pc;
    logic [kdl_pkg::IDX_W-1:0]   r_idx,   n_idx;
    logic [kdl_pkg::TRIES_W-1:0] r_wrong, n_wrong;
    logic [kdl_pkg::TICK_W-1:0]  r_tick,  n_tick;

    logic [N-1:0][DW-1:0] r_entry;
    logic [N-1:0][DW-1:0] r_first;
    logic [N-1:0][DW-1:0] r_stored;

    logic                        r_out_valid;
    logic [kdl_pkg::MODE_W-1:0]  r_status;
    logic [kdl_pkg::MOTOR_W-1:0] r_motor;
    logic                        r_buzzer;
    logic                        r_echo_valid;
    logic [DW-1:0]               r_echo_digit;

    logic [kdl_pkg::MODE_W-1:0]  cur_mode;
    logic [kdl_pkg::MODE_W-1:0]  status;
    logic [kdl_pkg::MODE_W-1:0]  tick_next;
    logic [kdl_pkg::TICK_W-1:0]  tick_limit;
    logic [kdl_pkg::TICK_W-1:0]  tick_inc;
    logic [kdl_pkg::TRIES_W-1:0] wrong_inc;
    logic                        timed;
    logic                        entry_we;
    logic                        first_we;
    logic                        stored_we;
    logic                        echo_valid;
    logic [DW-1:0]               echo_digit;
    logic [kdl_pkg::MOTOR_W-1:0] motor;

    // take the next item whenever the result register is free or being drained
    assign o_pop = i_item_valid && (!r_out_valid || !i_out_stall);

    assign tick_inc  = r_tick + 1'b1;
    assign wrong_inc = (r_wrong < kdl_pkg::TRIES_SAT) ? r_wrong + 1'b1 : r_wrong;

    always_comb begin
        n_pc       = r_pc;
        n_idx      = r_idx;
        n_wrong    = r_wrong;
        n_tick     = r_tick;
        entry_we   = 1'b0;
        first_we   = 1'b0;
        stored_we  = 1'b0;
        echo_valid = 1'b0;
        echo_digit = '0;
        timed      = 1'b1;
        tick_limit = r_open_ticks;
        tick_next  = kdl_pkg::M_MENU;

        // outcome codes and unknown codes fall back to the menu
        cur_mode = r_mode;
        if (r_mode > kdl_pkg::M_CLOSING || r_mode == kdl_pkg::S_SAVED ||
            r_mode == kdl_pkg::S_MISMATCH || r_mode == kdl_pkg::S_CORRECT ||
            r_mode == kdl_pkg::S_WRONG) begin
            cur_mode = kdl_pkg::M_MENU;
            n_idx    = '0;
        end
        n_mode = cur_mode;
        status = cur_mode;

        case (cur_mode)
            kdl_pkg::M_OPENING: begin
                tick_limit = r_open_ticks;
                tick_next  = kdl_pkg::M_OPENED;
            end
            kdl_pkg::M_OPENED: begin
                tick_limit = r_hold_ticks;
                tick_next  = kdl_pkg::M_CLOSING;
            end
            kdl_pkg::M_CLOSING: begin
                tick_limit = r_open_ticks;
                tick_next  = kdl_pkg::M_MENU;
            end
            kdl_pkg::M_LOCKED: begin
                tick_limit = r_lockout_ticks;
                tick_next  = kdl_pkg::M_MENU;
            end
            default: begin
                timed = 1'b0;
            end
        endcase

        if (i_item.kind == kdl_pkg::K_TICK) begin
            if (timed) begin
                n_tick = tick_inc;
                if (tick_inc >= tick_limit) begin
                    n_tick = '0;
                    n_mode = tick_next;
                    if (cur_mode == kdl_pkg::M_LOCKED) begin
                        n_wrong = '0;
                    end
                    if (tick_next == kdl_pkg::M_MENU) begin
                        n_idx = '0;
                    end
                end
            end
            status = n_mode;
        end else if (cur_mode == kdl_pkg::M_MENU) begin
            if (i_item.kind == kdl_pkg::K_MINUS || i_item.kind == kdl_pkg::K_PLUS) begin
                n_pc   = (i_item.kind == kdl_pkg::K_MINUS);
                n_mode = kdl_pkg::M_OLD;
                n_idx  = '0;
            end
            status = n_mode;
        end else if (cur_mode == kdl_pkg::M_NEW1 || cur_mode == kdl_pkg::M_NEW2 ||
                     cur_mode == kdl_pkg::M_OLD) begin
            if (r_idx < kdl_pkg::CODE_LEN) begin
                if (i_item.kind == kdl_pkg::K_DIGIT) begin
                    entry_we   = 1'b1;
                    n_idx      = r_idx + 1'b1;
                    echo_valid = 1'b1;
                    echo_digit = i_item.digit;
                end
            end else if (i_item.kind == kdl_pkg::K_ENTER) begin
                n_idx = '0;
                if (cur_mode == kdl_pkg::M_NEW1) begin
                    first_we = 1'b1;
                    n_mode   = kdl_pkg::M_NEW2;
                    status   = kdl_pkg::M_NEW2;
                end else if (cur_mode == kdl_pkg::M_NEW2) begin
                    if (r_first == r_entry) begin
                        stored_we = 1'b1;
                        n_mode    = kdl_pkg::M_MENU;
                        status    = kdl_pkg::S_SAVED;
                    end else begin
                        n_mode = kdl_pkg::M_NEW1;
                        status = kdl_pkg::S_MISMATCH;
                    end
                end else if (r_stored == r_entry) begin
                    n_wrong = '0;
                    if (r_pc) begin
                        n_mode = kdl_pkg::M_NEW1;
                        status = kdl_pkg::S_CORRECT;
                    end else begin
                        n_idx  = r_idx;
                        n_mode = kdl_pkg::M_OPENING;
                        n_tick = '0;
                        status = kdl_pkg::M_OPENING;
                    end
                end else begin
                    n_wrong = wrong_inc;
                    if (wrong_inc >= r_max_tries) begin
                        n_idx  = r_idx;
                        n_mode = kdl_pkg::M_LOCKED;
                        n_tick = '0;
                        status = kdl_pkg::M_LOCKED;
                    end else begin
                        n_mode = kdl_pkg::M_OLD;
                        status = kdl_pkg::S_WRONG;
                    end
                end
            end else begin
                // any other key after a full code restarts the entry
                n_idx = '0;
            end
        end

        if (n_mode == kdl_pkg::M_OPENING) begin
            motor = kdl_pkg::MOTOR_CW;
        end else if (n_mode == kdl_pkg::M_CLOSING) begin
            motor = kdl_pkg::MOTOR_CCW;
        end else begin
            motor = kdl_pkg::MOTOR_STOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_ticks    <= kdl_pkg::RST_OPEN_TICKS;
            r_hold_ticks    <= kdl_pkg::RST_HOLD_TICKS;
            r_lockout_ticks <= kdl_pkg::RST_LOCKOUT_TICKS;
            r_max_tries     <= kdl_pkg::RST_MAX_TRIES;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kdl_pkg::REG_OPEN_TICKS:    r_open_ticks    <= i_cfg_data;
                kdl_pkg::REG_HOLD_TICKS:    r_hold_ticks    <= i_cfg_data;
                kdl_pkg::REG_LOCKOUT_TICKS: r_lockout_ticks <= i_cfg_data;
                kdl_pkg::REG_MAX_TRIES:     r_max_tries     <= i_cfg_data[kdl_pkg::TRIES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= kdl_pkg::M_NEW1;
            r_pc        <= 1'b0;
            r_idx       <= '0;
            r_wrong     <= '0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode  <= n_mode;
                r_pc    <= n_pc;
                r_idx   <= n_idx;
                r_wrong <= n_wrong;
                r_tick  <= n_tick;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status     <= status;
            r_motor      <= motor;
            r_buzzer     <= (n_mode == kdl_pkg::M_LOCKED);
            r_echo_valid <= echo_valid;
            r_echo_digit <= echo_digit;
            for (int i = 0; i < N; i++) begin
                if (entry_we && r_idx == kdl_pkg::IDX_W'(i)) begin
                    r_entry[i] <= i_item.digit;
                end
            end
            if (first_we) begin
                r_first <= r_entry;
            end
            if (stored_we) begin
                r_stored <= r_entry;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_motor      = r_motor;
    assign o_buzzer     = r_buzzer;
    assign o_echo_valid = r_echo_valid;
    assign o_echo_digit = r_echo_digit;

endmodule

// ===== hw/rtl/keypad_door_lock_controller.sv =====
// top level of the keypad door lock controller: front classifier, item queue, lock engine
// depends on kdl_pkg, kdl_front, kdl_queue, kdl_back
//
//  channel  direction  handshake                    payload
//  in       input      i_in_valid / o_in_stall      i_func, i_key_code
//  out      output     o_out_valid / i_out_stall    o_status, o_motor, o_buzzer,
//                                                   o_echo_valid, o_echo_digit
//  cfg      input      i_cfg_we                     i_cfg_index, i_cfg_data
//
// one transaction per cycle sustained while i_out_stall is low; a result is registered
// after its input is written into the queue and popped by the state update
// the two-entry queue raises o_in_stall only when full, which happens only while
// i_out_stall holds the result register
// synchronous active-low reset returns to new-code entry with default timings;
// the code stores are undefined until first written
module keypad_door_lock_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kdl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kdl_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [kdl_pkg::KEY_W-1:0]     i_key_code,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [kdl_pkg::MODE_W-1:0]    o_status,
    output logic [kdl_pkg::MOTOR_W-1:0]   o_motor,
    output logic                          o_buzzer,
    output logic                          o_echo_valid,
    output logic [kdl_pkg::DIGIT_W-1:0]   o_echo_digit
);

    kdl_pkg::t_item front_item;
    kdl_pkg::t_item queue_item;
    logic           queue_full;
    logic           queue_valid;
    logic           queue_pop;
    logic           push;

    assign o_in_stall = queue_full;
    assign push       = i_in_valid && !queue_full;

    kdl_front u_front (
        .i_func     (i_func),
        .i_key_code (i_key_code),
        .o_item     (front_item)
    );

    kdl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (queue_pop),
        .o_item  (queue_item)
    );

    kdl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (queue_valid),
        .i_item       (queue_item),
        .o_pop        (queue_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_motor      (o_motor),
        .o_buzzer     (o_buzzer),
        .o_echo_valid (o_echo_valid),
        .o_echo_digit (o_echo_digit)
    );

endmodule

// ===== hw/rtl/kdl_checker.sv =====
// port-level checks for the keypad door lock controller, bound to the top level
// depends on kdl_pkg
module kdl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [kdl_pkg::MODE_W-1:0]    o_status,
    input logic [kdl_pkg::MOTOR_W-1:0]   o_motor,
    input logic                          o_buzzer,
    input logic                          o_echo_valid,
    input logic [kdl_pkg::DIGIT_W-1:0]   o_echo_digit
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_motor) &&
            $stable(o_buzzer) && $stable(o_echo_valid) && $stable(o_echo_digit))
        else $error("stalled result changed");

    // motor and buzzer follow the reported door and lockout status
    a_drive_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_motor == kdl_pkg::MOTOR_CW) == (o_status == kdl_pkg::M_OPENING)) &&
            ((o_motor == kdl_pkg::MOTOR_CCW) == (o_status == kdl_pkg::M_CLOSING)) &&
            (o_buzzer == (o_status == kdl_pkg::M_LOCKED)))
        else $error("motor or buzzer disagrees with status");

    // a digit echo only happens during code entry
    a_echo_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_echo_valid |->
            (o_status == kdl_pkg::M_NEW1 || o_status == kdl_pkg::M_NEW2 ||
             o_status == kdl_pkg::M_OLD) && o_echo_digit <= 4'd9)
        else $error("digit echo outside code entry");

    // no echo means a zero digit
    a_echo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_echo_valid |-> o_echo_digit == '0)
        else $error("echo digit without echo");

endmodule

bind keypad_door_lock_controller kdl_checker u_kdl_checker (.*);

// ===== test/tb.sv =====
// testbench for keypad_door_lock_controller: keypad and tick transactions with random idling
// on both channels, every result checked against an in-bench model of the lock
// depends on kdl_pkg and the keypad_door_lock_controller rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kdl_pkg::*;

    typedef logic [CODE_DIGITS-1:0][DIGIT_W-1:0] code_t;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] key;
    } key_event_t;

    typedef struct packed {
        logic [MODE_W-1:0]  status;
        logic [MOTOR_W-1:0] motor;
        logic               buzzer;
        logic               echo_valid;
        logic [DIGIT_W-1:0] echo_digit;
    } panel_t;

    typedef enum logic [1:0] {AIM_MIX, AIM_OPEN, AIM_LOCK} aim_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_OPEN_TICKS;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic                  in_func   = 1'b0;
    logic [KEY_W-1:0]      in_key    = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [MODE_W-1:0]     status;
    logic [MOTOR_W-1:0]    motor;
    logic                  buzzer;
    logic                  echo_valid;
    logic [DIGIT_W-1:0]    echo_digit;

    keypad_door_lock_controller dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_func       (in_func),
        .i_key_code   (in_key),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_status     (status),
        .o_motor      (motor),
        .o_buzzer     (buzzer),
        .o_echo_valid (echo_valid),
        .o_echo_digit (echo_digit)
    );

    // lock model state, reset values
    logic [MODE_W-1:0]  lk_mode   = M_NEW1;
    logic               lk_change = 1'b0;
    logic [IDX_W-1:0]   lk_index  = '0;
    code_t              lk_entry  = '0;
    code_t              lk_first  = '0;
    code_t              lk_stored = '0;
    logic [TRIES_W-1:0] lk_wrong  = '0;
    logic [TICK_W-1:0]  lk_ticks  = '0;
    logic [TICK_W-1:0]  cfg_open    = RST_OPEN_TICKS;
    logic [TICK_W-1:0]  cfg_hold    = RST_HOLD_TICKS;
    logic [TICK_W-1:0]  cfg_lockout = RST_LOCKOUT_TICKS;
    logic [TRIES_W-1:0] cfg_tries   = RST_MAX_TRIES;
    int unsigned        doors_closed    = 0;
    int unsigned        lockouts_served = 0;

    key_event_t  key_events[$];
    panel_t      panel_expected[$];
    key_event_t  next_event;
    panel_t      want;
    int unsigned events_pushed  = 0;
    int unsigned events_taken   = 0;
    int unsigned live_count     = 0;
    int unsigned mismatch_count = 0;
    int unsigned send_gap  = 0;
    int unsigned hold_gap  = 0;
    bit          send_calm = 1'b0;
    bit          hold_calm = 1'b0;

    initial begin
        clk = 1'b0;
        forever #1 clk = !clk;
    end

    function automatic logic [TICK_W-1:0] phase_limit(input logic [MODE_W-1:0] m);
        case (m)
            M_OPENING, M_CLOSING: return cfg_open;
            M_OPENED: return cfg_hold;
            default: return cfg_lockout;
        endcase
    endfunction

    function automatic void tick_lock();
        logic [MODE_W-1:0] next_mode;
        case (lk_mode)
            M_OPENING: next_mode = M_OPENED;
            M_OPENED: next_mode = M_CLOSING;
            M_CLOSING, M_LOCKED: next_mode = M_MENU;
            default: return;
        endcase
        lk_ticks = lk_ticks + 1'b1;
        if (lk_ticks >= phase_limit(lk_mode)) begin
            lk_ticks = '0;
            if (lk_mode == M_LOCKED) begin
                lk_wrong = '0;
                lockouts_served++;
            end
            if (lk_mode == M_CLOSING)
                doors_closed++;
            lk_mode = next_mode;
            if (next_mode == M_MENU)
                lk_index = '0;
        end
    endfunction

    // enter after a full code; returns the status shown for this transaction
    function automatic logic [MODE_W-1:0] confirm_code();
        if (lk_mode == M_NEW1) begin
            lk_first = lk_entry;
            lk_mode  = M_NEW2;
            lk_index = '0;
            return M_NEW2;
        end
        if (lk_mode == M_NEW2) begin
            lk_index = '0;
            if (lk_first == lk_entry) begin
                lk_stored = lk_entry;
                lk_mode   = M_MENU;
                return S_SAVED;
            end
            lk_mode = M_NEW1;
            return S_MISMATCH;
        end
        if (lk_stored == lk_entry) begin
            lk_wrong = '0;
            if (lk_change) begin
                lk_mode  = M_NEW1;
                lk_index = '0;
                return S_CORRECT;
            end
            lk_mode  = M_OPENING;
            lk_ticks = '0;
            return M_OPENING;
        end
        if (lk_wrong < TRIES_SAT)
            lk_wrong = lk_wrong + 1'b1;
        if (lk_wrong >= cfg_tries) begin
            lk_mode  = M_LOCKED;
            lk_ticks = '0;
            return M_LOCKED;
        end
        lk_mode  = M_OLD;
        lk_index = '0;
        return S_WRONG;
    endfunction

    function automatic panel_t lock_advance(input logic func, input logic [KEY_W-1:0] key);
        panel_t p;
        p = '0;
        if (func) begin
            tick_lock();
            p.status = lk_mode;
        end else if (lk_mode == M_MENU) begin
            if (key == KEY_MINUS || key == KEY_PLUS) begin
                lk_change = (key == KEY_MINUS);
                lk_mode   = M_OLD;
                lk_index  = '0;
            end
            p.status = lk_mode;
        end else if (lk_mode == M_NEW1 || lk_mode == M_NEW2 || lk_mode == M_OLD) begin
            p.status = lk_mode;
            if (lk_index < CODE_LEN) begin
                if (key <= KEY_MAX_DIG) begin
                    lk_entry[lk_index] = key[DIGIT_W-1:0];
                    lk_index     = lk_index + 1'b1;
                    p.echo_valid = 1'b1;
                    p.echo_digit = key[DIGIT_W-1:0];
                end
            end else if (key == KEY_ENTER) begin
                p.status = confirm_code();
            end else begin
                lk_index = '0;
            end
        end else begin
            p.status = lk_mode;
        end
        p.motor  = (lk_mode == M_OPENING) ? MOTOR_CW :
                   (lk_mode == M_CLOSING) ? MOTOR_CCW : MOTOR_STOP;
        p.buzzer = (lk_mode == M_LOCKED);
        return p;
    endfunction

    function automatic int unsigned pause_len(input bit calm);
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic [TICK_W-1:0] tick_setting();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 2)
            return '0;
        if (roll < 4)
            return TICK_W'(1);
        if (roll == 4)
            return TICK_W'($urandom_range(25, 60));
        return TICK_W'($urandom_range(2, 24));
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, exp_val);
    endtask

    // input side: one transaction per accepted item, pause drawn after each
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                panel_expected.push_back(lock_advance(in_func, in_key));
                events_taken++;
                if ($urandom_range(0, 39) == 0)
                    send_calm = !send_calm;
                send_gap = pause_len(send_calm);
            end
            if (!in_valid || !in_stall) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (key_events.size() != 0) begin
                    next_event = key_events.pop_front();
                    in_func  <= next_event.func;
                    in_key   <= next_event.key;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: check each result, then stall for a drawn number of cycles
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (panel_expected.size() == 0) begin
                    report_mismatch("unexpected result, status", status, 0);
                end else begin
                    want = panel_expected.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (motor !== want.motor)
                        report_mismatch("motor", motor, want.motor);
                    if (buzzer !== want.buzzer)
                        report_mismatch("buzzer", buzzer, want.buzzer);
                    if (echo_valid !== want.echo_valid)
                        report_mismatch("echo_valid", echo_valid, want.echo_valid);
                    if (echo_digit !== want.echo_digit)
                        report_mismatch("echo_digit", echo_digit, want.echo_digit);
                end
                if ($urandom_range(0, 39) == 0)
                    hold_calm = !hold_calm;
                hold_gap = pause_len(hold_calm);
            end
            if (hold_gap != 0) begin
                hold_gap--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_event(input logic func, input logic [KEY_W-1:0] key);
        key_events.push_back('{func: func, key: key});
        events_pushed++;
        live_count++;
    endtask

    // items not counted in live_count; most leave the lock state unchanged
    task automatic push_noise(input logic func, input logic [KEY_W-1:0] key);
        key_events.push_back('{func: func, key: key});
        events_pushed++;
    endtask

    task automatic push_code(input code_t digits, input int from, input bit noisy);
        int i;
        for (i = from; i < CODE_DIGITS; i++) begin
            if (noisy && $urandom_range(0, 11) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    push_noise(1'b1, KEY_W'($urandom_range(0, 255)));
                else
                    push_noise(1'b0, KEY_W'($urandom_range(10, 255)));
            end
            push_event(1'b0, KEY_W'(digits[i]));
        end
    endtask

    task automatic wait_fed();
        while (events_taken != events_pushed)
            @(posedge clk);
    endtask

    task automatic wait_quiet();
        while (events_taken != events_pushed || panel_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_OPEN_TICKS: cfg_open = value;
            REG_HOLD_TICKS: cfg_hold = value;
            REG_LOCKOUT_TICKS: cfg_lockout = value;
            default: cfg_tries = value[TRIES_W-1:0];
        endcase
    endtask

    task automatic set_lock_regs(input logic [TICK_W-1:0] open_t, input logic [TICK_W-1:0] hold_t,
                                 input logic [TICK_W-1:0] lock_t, input logic [TRIES_W-1:0] tries);
        write_reg(REG_OPEN_TICKS, open_t);
        write_reg(REG_HOLD_TICKS, hold_t);
        write_reg(REG_LOCKOUT_TICKS, lock_t);
        write_reg(REG_MAX_TRIES, CFG_W'(tries));
    endtask

    // push the next sequence from the current model state; call only when fed
    task automatic plan_step(input aim_t aim);
        code_t       target;
        int unsigned roll;
        int unsigned left;
        int unsigned pos;
        int unsigned d;
        int          i;
        roll = $urandom_range(0, 99);
        case (lk_mode)
            M_MENU: begin
                if (aim != AIM_MIX || roll < 55)
                    push_event(1'b0, KEY_PLUS);
                else if (roll < 85)
                    push_event(1'b0, KEY_MINUS);
                else
                    push_noise(roll[0], KEY_W'($urandom_range(0, 255)));
            end
            M_NEW1, M_NEW2, M_OLD: begin
                if (lk_index < CODE_LEN) begin
                    for (i = 0; i < CODE_DIGITS; i++)
                        target[i] = DIGIT_W'($urandom_range(0, 9));
                    if (lk_mode == M_NEW2 && (aim != AIM_MIX || roll < 75))
                        target = lk_first;
                    if (lk_mode == M_OLD) begin
                        target = lk_stored;
                        if (aim == AIM_LOCK || (aim == AIM_MIX && roll < 30)) begin
                            pos = $urandom_range(0, CODE_DIGITS - 1);
                            d = target[pos] + $urandom_range(1, 9);
                            if (d > 9)
                                d = d - 10;
                            target[pos] = DIGIT_W'(d);
                        end
                    end
                    push_code(target, int'(lk_index), aim == AIM_MIX);
                end else if (aim != AIM_MIX || roll < 85) begin
                    push_event(1'b0, KEY_ENTER);
                end else if (roll < 95) begin
                    // anything but enter throws the entry away
                    d = $urandom_range(0, 255);
                    if (d == KEY_ENTER)
                        d = 0;
                    push_event(1'b0, KEY_W'(d));
                end else begin
                    push_noise(1'b1, KEY_W'($urandom_range(0, 255)));
                end
            end
            default: begin
                left = (phase_limit(lk_mode) > lk_ticks) ?
                       int'(phase_limit(lk_mode) - lk_ticks) : 1;
                if (aim == AIM_MIX && roll < 20)
                    left = $urandom_range(1, left);
                repeat (left) begin
                    if ($urandom_range(0, 9) == 0)
                        push_noise(1'b0, KEY_W'($urandom_range(0, 255)));
                    push_event(1'b1, KEY_W'($urandom_range(0, 255)));
                end
            end
        endcase
    endtask

    initial begin
        code_t       door_code;
        int unsigned phase;
        int unsigned mark;
        door_code = {4'd9, 4'd0, 4'd0, 4'd9, 4'd0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: code setup, menu, door open under reset timings
        push_noise(1'b1, 8'hFF);
        push_noise(1'b0, 8'hFF);
        push_noise(1'b0, 8'd10);
        push_code(door_code, 0, 1'b0);
        push_event(1'b0, KEY_ENTER);
        push_code(door_code, 0, 1'b0);
        push_event(1'b0, KEY_ENTER);
        push_noise(1'b0, KEY_ENTER);
        push_noise(1'b1, 8'h00);
        push_event(1'b0, KEY_PLUS);
        push_code(door_code, 0, 1'b0);
        push_event(1'b0, KEY_ENTER);
        push_noise(1'b0, 8'd9);
        wait_quiet();
        // zero registers end each phase on its first tick
        set_lock_regs('0, '0, '0, '0);
        repeat (3)
            push_event(1'b1, KEY_W'($urandom_range(0, 255)));

        for (phase = 0; phase < 6; phase++) begin
            wait_quiet();
            set_lock_regs(tick_setting(), tick_setting(), tick_setting(),
                          TRIES_W'($urandom_range(0, 7)));
            mark = live_count;
            wait_fed();
            while (live_count - mark < 150) begin
                plan_step(AIM_MIX);
                wait_fed();
            end
        end

        // long hold and lockout with the most tries
        wait_quiet();
        set_lock_regs('0, 11'd300, 11'd500, 3'd7);
        mark = doors_closed;
        while (doors_closed == mark) begin
            plan_step(AIM_OPEN);
            wait_fed();
        end
        mark = lockouts_served;
        while (lockouts_served == mark) begin
            plan_step(AIM_LOCK);
            wait_fed();
        end

        wait_quiet();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
